>>> rtl/assert_macros.svh
// Assertion macros used by the checker file bsfe_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BSFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication
`define BSFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> rtl/bsfe_pkg.sv
// Package for the byte-stuffed frame encoder: byte constants, request codes
// and the burst type passed from the encoder stage to the serialiser.
// No dependencies.
package bsfe_pkg;

	localparam logic [7:0] FLAG_BYTE = 8'h7e;
	localparam logic [7:0] ESC_BYTE  = 8'h7d;
	localparam logic [7:0] ESC_MASK  = 8'h20;
	localparam logic [7:0] INV_MASK  = 8'hff;

	localparam logic [1:0] REQ_START   = 2'd0;
	localparam logic [1:0] REQ_PAYLOAD = 2'd1;
	localparam logic [1:0] REQ_END     = 2'd2;

	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      cnt;
		logic            close;
	} burst_t;

endpackage

>>> rtl/bsfe_encode.sv
// Input register, frame state and stuffing logic of the frame encoder.
// Produces one burst of up to three bytes per item. Uses bsfe_pkg.
module bsfe_encode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          req_type,
	input  logic [7:0]          command_code,
	input  logic [7:0]          device_id,
	input  logic [7:0]          data_byte,
	input  logic                burst_ready,
	output logic                burst_valid,
	output bsfe_pkg::burst_t    burst
);

	logic       valid_s1;
	logic [1:0] req_s1;
	logic [7:0] cmd_s1;
	logic [7:0] id_s1;
	logic [7:0] data_s1;
	logic [7:0] xor_q;
	logic       open_q;

	logic       advance;
	logic       accept;
	logic [7:0] xor_d;
	logic       open_d;
	logic [7:0] hdr;
	logic [7:0] sel;
	logic [7:0] sel_x;
	logic       sel_esc;

	assign advance  = valid_s1 && burst_ready;
	assign in_stall = valid_s1 && !burst_ready;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req_type;
			cmd_s1  <= command_code;
			id_s1   <= device_id;
			data_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_q  <= '0;
			open_q <= 1'b0;
		end else if (advance) begin
			xor_q  <= xor_d;
			open_q <= open_d;
		end
	end

	always_comb begin
		hdr     = cmd_s1 | id_s1;
		sel     = (req_s1 == bsfe_pkg::REQ_END) ? (xor_q ^ bsfe_pkg::INV_MASK) : data_s1;
		sel_x   = sel ^ bsfe_pkg::ESC_MASK;
		sel_esc = (sel == bsfe_pkg::FLAG_BYTE) || (sel == bsfe_pkg::ESC_BYTE);
		burst   = '0;
		xor_d   = xor_q;
		open_d  = open_q;
		case (req_s1)
			bsfe_pkg::REQ_START: begin
				burst.bytes[0] = bsfe_pkg::FLAG_BYTE;
				burst.bytes[1] = hdr;
				burst.cnt      = 2'd2;
				xor_d          = hdr;
				open_d         = 1'b1;
			end
			bsfe_pkg::REQ_PAYLOAD: begin
				if (open_q) begin
					if (sel_esc) begin
						burst.bytes[0] = bsfe_pkg::ESC_BYTE;
						burst.bytes[1] = sel_x;
						burst.cnt      = 2'd2;
						xor_d          = xor_q ^ bsfe_pkg::ESC_BYTE ^ sel_x;
					end else begin
						burst.bytes[0] = sel;
						burst.cnt      = 2'd1;
						xor_d          = xor_q ^ sel;
					end
				end
			end
			bsfe_pkg::REQ_END: begin
				if (open_q) begin
					if (sel_esc) begin
						burst.bytes[0] = bsfe_pkg::ESC_BYTE;
						burst.bytes[1] = sel_x;
						burst.bytes[2] = bsfe_pkg::FLAG_BYTE;
						burst.cnt      = 2'd3;
					end else begin
						burst.bytes[0] = sel;
						burst.bytes[1] = bsfe_pkg::FLAG_BYTE;
						burst.cnt      = 2'd2;
					end
					burst.close = 1'b1;
					xor_d       = '0;
					open_d      = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign burst_valid = advance && (burst.cnt != 2'd0);

endmodule

>>> rtl/bsfe_serial.sv
// Result register of the frame encoder: holds one burst and hands its
// bytes out one per cycle while out_stall is low. Uses bsfe_pkg.
module bsfe_serial (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                burst_valid,
	input  bsfe_pkg::burst_t    burst,
	output logic                burst_ready,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          out_byte,
	output logic                run_last,
	output logic                frame_done
);

	logic             busy_q;
	logic [1:0]       idx_q;
	bsfe_pkg::burst_t burst_q;
	logic             take;

	assign take        = busy_q && !out_stall;
	assign run_last    = idx_q == (burst_q.cnt - 2'd1);
	assign burst_ready = !busy_q || (take && run_last);
	assign out_valid   = busy_q;
	assign out_byte    = burst_q.bytes[idx_q];
	assign frame_done  = burst_q.close && run_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (burst_valid) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			if (run_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (burst_valid) begin
			burst_q <= burst;
		end
	end

endmodule

>>> rtl/byte_stuffed_frame_encoder_top.sv
// Channel | handshake          | fields
// in      | in_valid/in_stall  | req_type, command_code, device_id, data_byte
// out     | out_valid/out_stall| out_byte, run_last, frame_done
//
// An item is held in the input register, then its burst of 1 to 3 bytes,
// if it has any, is loaded into the result register, which offers its first
// byte; while that register is busy, the item waits in the input register.
// The result register sends one byte per cycle while out_stall is low, and
// holds an item until all of its bytes (1 to 3) have left.
// Reset clears the frame state and all valid flags. out_stall holds the
// current byte; in_stall rises once the input register cannot move on.
// Top level of the byte-stuffed frame encoder; instantiates bsfe_encode and
// bsfe_serial, uses bsfe_pkg.
module byte_stuffed_frame_encoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [7:0] command_code,
	input  logic [7:0] device_id,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       frame_done
);

	logic             burst_valid;
	logic             burst_ready;
	bsfe_pkg::burst_t burst;

	bsfe_encode u_encode (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.command_code (command_code),
		.device_id    (device_id),
		.data_byte    (data_byte),
		.burst_ready  (burst_ready),
		.burst_valid  (burst_valid),
		.burst        (burst)
	);

	bsfe_serial u_serial (
		.clk         (clk),
		.arst_n      (arst_n),
		.burst_valid (burst_valid),
		.burst       (burst),
		.burst_ready (burst_ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.frame_done  (frame_done)
	);

endmodule

>>> rtl/bsfe_checker.sv
// Port-level checker for the frame encoder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module bsfe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       frame_done
);

	`BSFE_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`BSFE_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(out_byte))
	`BSFE_ASSERT_IMP(a_close_flag, clk, arst_n, out_valid && frame_done, run_last && (out_byte == 8'h7e))
	`BSFE_ASSERT_NXT(a_burst_cont, clk, arst_n, out_valid && !out_stall && !run_last, out_valid)

endmodule

bind byte_stuffed_frame_encoder_top bsfe_checker u_bsfe_checker (.*);
